/* hw/rtl/dns_answer_address_extractor_macros.svh */
// Assertion macros used by the checker file of the DNS answer address extractor.
`ifndef DNS_ANSWER_ADDRESS_EXTRACTOR_MACROS_SVH
`define DNS_ANSWER_ADDRESS_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define DNSAE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define DNSAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dnsae_pkg.sv */
// Types, constants and codes shared by the DNS answer address extractor modules.
`default_nettype none

package dnsae_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 4096;

    localparam int          HDR_LAST_POS = 11;
    localparam int          QTAIL_LEN    = 4;
    localparam int          FIXED_LEN    = 10;
    localparam logic [7:0]  PTR_MARK     = 8'hC0;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] TYPE_AAAA    = 16'd28;
    localparam logic [15:0] LEN_A        = 16'd4;
    localparam logic [15:0] LEN_AAAA     = 16'd16;

    localparam logic KIND_ADDR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;
    localparam logic FAM_V4       = 1'b0;
    localparam logic FAM_V6       = 1'b1;

    localparam int OUTQ_DEPTH = 4;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_QNAME,
        PH_QLABEL,
        PH_QPTR,
        PH_QTAIL,
        PH_ANAME,
        PH_ALABEL,
        PH_APTR,
        PH_AFIXED,
        PH_ARDATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT,
        ST_BAD_QUESTION,
        ST_NO_ADDRESS
    } status_t;

    typedef struct packed {
        logic        kind;
        logic        family;
        logic [63:0] upper;
        logic [63:0] lower;
        logic [15:0] id;
        logic        qr;
        logic [3:0]  rcode;
        status_t     status;
        logic [15:0] count;
        logic        last;
    } result_t;

    // Writes into the result queue caused by one byte.
    typedef struct packed {
        logic one;
        logic two;
    } push_t;

endpackage

`default_nettype wire

/* hw/rtl/dns_answer_address_extractor.sv */
// A result is written into the result queue registers on the transfer of its byte and leaves from the queue head.
// Throughput: one byte per cycle while s_tready is high; a byte that ends an address record and the packet
// causes two results, which leave one after the other from a four-entry result queue.
// s_tready drops only while that queue holds more than two results.
// Reset: rst_n is asynchronous and active low; it clears the parser and empties the queue.
`default_nettype none

module dns_answer_address_extractor
    import dnsae_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,   // end_of_packet
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // addr_upper[63:0], addr_lower[127:64], message_id[143:128], is_response[144],
    // response_code[148:145], parse_status[150:149], address_count[166:151], zero[167]
    output logic [167:0]      m_tdata,
    output logic [1:0]        m_tuser,   // result_kind[0], addr_family[1]
    output logic              m_tlast    // last_of_run
);

    // The parser keeps the whole packet state in registers and updates it on every
    // byte transfer. The results of a byte go straight into the queue, which acts as
    // the result register and lets the input side keep running while the output stalls.

    logic    accept;
    result_t res0;
    result_t res1;
    result_t head;
    push_t   push;
    logic    room;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = room;

    dnsae_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .res0    (res0),
        .res1    (res1),
        .push    (push)
    );

    dnsae_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata0    (res0),
        .wdata1    (res1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // Pack the result fields onto the stream, first field in the lowest bits.
    assign m_tdata = {1'b0, head.count, head.status, head.rcode, head.qr, head.id,
                      head.lower, head.upper};
    assign m_tuser = {head.family, head.kind};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

/* hw/rtl/dnsae_parser.sv */
// Byte-level DNS response parser: header capture, name skipping and rdata collection.
`default_nettype none

module dnsae_parser
    import dnsae_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output result_t         res0,
    output result_t         res1,
    output push_t           push
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [POS_W-1:0] pos_reg,   pos_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      id_reg,    id_next;
    logic [15:0]      flags_reg, flags_next;
    logic [15:0]      ans_reg,   ans_next;
    logic [7:0]       skip_reg,  skip_next;
    logic [15:0]      rtype_reg, rtype_next;
    logic [15:0]      rdrem_reg, rdrem_next;
    logic [63:0]      sh0_reg,   sh0_next;
    logic [63:0]      sh1_reg,   sh1_next;
    logic [15:0]      found_reg, found_next;

    logic    finish;
    logic    emit;
    logic    ok_len;
    logic    is_question;
    logic    hdr_seen;
    status_t status;
    result_t addr_res;
    result_t sum_res;

    always_comb
    begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        id_next     = id_reg;
        flags_next  = flags_reg;
        ans_next    = ans_reg;
        skip_next   = skip_reg;
        rtype_next  = rtype_reg;
        rdrem_next  = rdrem_reg;
        sh0_next    = sh0_reg;
        sh1_next    = sh1_reg;
        found_next  = found_reg;
        finish      = 1'b0;
        emit        = 1'b0;
        ok_len      = 1'b0;
        is_question = (phase_reg == PH_QNAME);
        hdr_seen    = 1'b0;
        status      = ST_OK;

        if (accept && (pos_reg < POS_W'(MAX_PACKET_BYTES)))
        begin
            pos_next = pos_reg + 1'b1;
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (pos_reg == POS_W'(0)) id_next = {in_byte, 8'd0};
                    if (pos_reg == POS_W'(1)) id_next = {id_reg[15:8], in_byte};
                    if (pos_reg == POS_W'(2)) flags_next = {in_byte, 8'd0};
                    if (pos_reg == POS_W'(3)) flags_next = {flags_reg[15:8], in_byte};
                    if (pos_reg == POS_W'(6)) ans_next = {in_byte, 8'd0};
                    if (pos_reg == POS_W'(7)) ans_next = {ans_reg[15:8], in_byte};
                    if (pos_reg >= POS_W'(HDR_LAST_POS)) phase_next = PH_QNAME;
                end
                PH_QNAME, PH_ANAME:
                begin
                    if ((in_byte & PTR_MARK) == PTR_MARK)
                    begin
                        phase_next = is_question ? PH_QPTR : PH_APTR;
                    end
                    else if (in_byte == 8'd0)
                    begin
                        if (is_question)
                        begin
                            phase_next = PH_QTAIL;
                            skip_next  = 8'(QTAIL_LEN);
                        end
                        else
                        begin
                            phase_next = PH_AFIXED;
                            skip_next  = 8'(FIXED_LEN);
                            rtype_next = 16'd0;
                            rdrem_next = 16'd0;
                        end
                    end
                    else
                    begin
                        skip_next  = in_byte;
                        phase_next = is_question ? PH_QLABEL : PH_ALABEL;
                    end
                end
                PH_QLABEL:
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 8'd1) phase_next = PH_QNAME;
                end
                PH_ALABEL:
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 8'd1) phase_next = PH_ANAME;
                end
                PH_QPTR:
                begin
                    phase_next = PH_QTAIL;
                    skip_next  = 8'(QTAIL_LEN);
                end
                PH_QTAIL:
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 8'd1) phase_next = (ans_reg != 16'd0) ? PH_ANAME : PH_DONE;
                end
                PH_APTR:
                begin
                    phase_next = PH_AFIXED;
                    skip_next  = 8'(FIXED_LEN);
                    rtype_next = 16'd0;
                    rdrem_next = 16'd0;
                end
                PH_AFIXED:
                begin
                    // Type is the first two of the ten fixed bytes, rdlength the last two.
                    if (skip_reg >= 8'(FIXED_LEN - 1)) rtype_next = {rtype_reg[7:0], in_byte};
                    if (skip_reg <= 8'd2) rdrem_next = {rdrem_reg[7:0], in_byte};
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 8'd1)
                    begin
                        ok_len = ((rtype_next == TYPE_A) && (rdrem_next == LEN_A)) ||
                                 ((rtype_next == TYPE_AAAA) && (rdrem_next == LEN_AAAA));
                        if (!ok_len) rtype_next = 16'd0;
                        sh0_next = 64'd0;
                        sh1_next = 64'd0;
                        if (rdrem_next == 16'd0) finish = 1'b1;
                        else phase_next = PH_ARDATA;
                    end
                end
                PH_ARDATA:
                begin
                    sh0_next   = {sh0_reg[55:0], sh1_reg[63:56]};
                    sh1_next   = {sh1_reg[55:0], in_byte};
                    rdrem_next = rdrem_reg - 1'b1;
                    if (rdrem_reg == 16'd1) finish = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (finish)
        begin
            emit = (rtype_next == TYPE_A) || (rtype_next == TYPE_AAAA);
            if (emit && (found_reg != 16'hFFFF)) found_next = found_reg + 1'b1;
            ans_next   = ans_reg - 1'b1;
            phase_next = (ans_next != 16'd0) ? PH_ANAME : PH_DONE;
        end

        addr_res.kind   = KIND_ADDR;
        addr_res.family = (rtype_next == TYPE_AAAA) ? FAM_V6 : FAM_V4;
        addr_res.upper  = (rtype_next == TYPE_AAAA) ? sh0_next : 64'd0;
        addr_res.lower  = (rtype_next == TYPE_AAAA) ? sh1_next : {32'd0, sh1_next[31:0]};
        addr_res.id     = id_next;
        addr_res.qr     = flags_next[15];
        addr_res.rcode  = flags_next[3:0];
        addr_res.status = ST_OK;
        addr_res.count  = found_next;
        addr_res.last   = !in_last;

        hdr_seen = (phase_next != PH_HDR);
        if (!hdr_seen) status = ST_SHORT;
        else if (phase_next <= PH_QTAIL) status = ST_BAD_QUESTION;
        else if (found_next == 16'd0) status = ST_NO_ADDRESS;
        else status = ST_OK;

        sum_res.kind   = KIND_SUMMARY;
        sum_res.family = FAM_V4;
        sum_res.upper  = 64'd0;
        sum_res.lower  = 64'd0;
        sum_res.id     = hdr_seen ? id_next : 16'd0;
        sum_res.qr     = hdr_seen ? flags_next[15] : 1'b0;
        sum_res.rcode  = hdr_seen ? flags_next[3:0] : 4'd0;
        sum_res.status = status;
        sum_res.count  = found_next;
        sum_res.last   = 1'b1;

        // The summary closes the packet and returns all state to its reset value.
        if (accept && in_last)
        begin
            pos_next   = '0;
            phase_next = PH_HDR;
            id_next    = 16'd0;
            flags_next = 16'd0;
            ans_next   = 16'd0;
            skip_next  = 8'd0;
            rtype_next = 16'd0;
            rdrem_next = 16'd0;
            sh0_next   = 64'd0;
            sh1_next   = 64'd0;
            found_next = 16'd0;
        end
    end

    assign res0     = emit ? addr_res : sum_res;
    assign res1     = sum_res;
    assign push.one = accept && (emit || in_last);
    assign push.two = accept && emit && in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_HDR;
            id_reg    <= 16'd0;
            flags_reg <= 16'd0;
            ans_reg   <= 16'd0;
            skip_reg  <= 8'd0;
            rtype_reg <= 16'd0;
            rdrem_reg <= 16'd0;
            sh0_reg   <= 64'd0;
            sh1_reg   <= 64'd0;
            found_reg <= 16'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            id_reg    <= id_next;
            flags_reg <= flags_next;
            ans_reg   <= ans_next;
            skip_reg  <= skip_next;
            rtype_reg <= rtype_next;
            rdrem_reg <= rdrem_next;
            sh0_reg   <= sh0_next;
            sh1_reg   <= sh1_next;
            found_reg <= found_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dnsae_outq.sv */
// Small result queue that takes up to two results per cycle and hands out one.
`default_nettype none

module dnsae_outq
    import dnsae_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    input  wire result_t wdata0,
    input  wire result_t wdata1,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    result_t          mem_reg [OUTQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem_reg[rd_ptr_reg];
    // Room for the two results that one byte can cause.
    assign room         = (count_reg <= CNT_W'(OUTQ_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.one) + PTR_W'(push.two);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.one) + CNT_W'(push.two) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.one) mem_reg[wr_ptr_reg] <= wdata0;
        if (push.two) mem_reg[wr_ptr_plus1] <= wdata1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dnsae_checker.sv */
// Port-level checker for the DNS answer address extractor and its bind statement.
`default_nettype none

`include "dns_answer_address_extractor_macros.svh"

module dnsae_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [167:0] m_tdata,
    input wire logic [1:0]   m_tuser,
    input wire logic         m_tlast
);

    `DNSAE_ASSERT_NEXT(a_valid_holds, m_tvalid && !m_tready, m_tvalid,
        "m_tvalid dropped while stalled")
    `DNSAE_ASSERT_IMPLY(a_summary_last, m_tvalid && m_tuser[0], m_tlast,
        "summary without tlast")
    `DNSAE_ASSERT_IMPLY(a_record_status, m_tvalid && !m_tuser[0],
        m_tdata[150:149] == 2'b00, "address record with nonzero status")
    `DNSAE_ASSERT_IMPLY(a_summary_empty, m_tvalid && m_tuser[0],
        !m_tuser[1] && (m_tdata[127:0] == 128'd0), "summary carries address bits")
    `DNSAE_ASSERT_NEXT(a_summary_follows, m_tvalid && m_tready && !m_tuser[0] && !m_tlast,
        m_tvalid && m_tuser[0], "record not followed by its summary")

endmodule

bind dns_answer_address_extractor dnsae_checker u_dnsae_checker (.*);

`default_nettype wire
